FILE: rtl/core/owrs_pkg.sv
// Shared types, codes and the CRC8 bit step for the ROM search core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package owrs_pkg;

    localparam int RomBits = 64;
    localparam int PosW    = 7;
    localparam int IdxW    = $clog2(RomBits);
    localparam logic [7:0] CrcPoly = 8'h8C;

    // Input operation codes.
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_BEGIN   = 2'd1;
    localparam logic [1:0] OP_PAIR    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_RESTARTED   = 3'd0;
    localparam logic [2:0] ST_PASS_START  = 3'd1;
    localparam logic [2:0] ST_BIT_TAKEN   = 3'd2;
    localparam logic [2:0] ST_ROM_DONE    = 3'd3;
    localparam logic [2:0] ST_SWEEP_OVER  = 3'd4;
    localparam logic [2:0] ST_NO_DEVICE   = 3'd5;
    localparam logic [2:0] ST_NO_RESPONSE = 3'd6;
    localparam logic [2:0] ST_NOT_IN_PASS = 3'd7;

    typedef struct packed {
        logic [RomBits-1:0] path_bits;
        logic [PosW-1:0]    last_fork;
        logic [PosW-1:0]    newest_zero_fork;
        logic [PosW-1:0]    bit_position;
        logic               in_pass;
        logic               sweep_done;
        logic [7:0]         running_crc;
    } t_state;

    typedef struct packed {
        logic       cmp_bit;
        logic       id_bit;
        logic       presence;
        logic [1:0] op;
    } t_item;

    typedef struct packed {
        logic               sweep_finished;
        logic               rom_crc_ok;
        logic [RomBits-1:0] rom_code;
        logic               write_bit;
        logic [2:0]         status;
    } t_result;

    localparam t_state StateReset = '{
        path_bits:        '0,
        last_fork:        '0,
        newest_zero_fork: '0,
        bit_position:     PosW'(1),
        in_pass:          1'b0,
        sweep_done:       1'b0,
        running_crc:      8'h00
    };

    // One bit of the reflected CRC8, least significant bit first.
    function automatic logic [7:0] crc_shift(input logic [7:0] crc, input logic bit_in);
        logic [7:0] shifted;
        shifted = {1'b0, crc[7:1]};
        return (crc[0] ^ bit_in) ? (shifted ^ CrcPoly) : shifted;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/owrs_step.sv
// Next-state and result logic for one item of the ROM search walk.
// Depends on owrs_pkg for the state, item and result types and the CRC step.
`default_nettype none

module owrs_step
    import owrs_pkg::*;
(
    input  var t_state  i_state,
    input  var t_item   i_item,
    output t_state      o_state,
    output t_result     o_result
);

    logic [PosW-1:0] pos;
    logic [IdxW-1:0] idx;
    logic            fork_here;
    logic            take;
    t_state          pair_state;

    assign pos       = i_state.bit_position;
    assign idx       = IdxW'(pos - PosW'(1));
    assign fork_here = (i_item.id_bit == i_item.cmp_bit);

    always_comb begin
        if (!fork_here) begin
            take = i_item.id_bit;
        end else if (pos < i_state.last_fork) begin
            take = i_state.path_bits[idx];
        end else if (pos == i_state.last_fork) begin
            take = 1'b1;
        end else begin
            take = 1'b0;
        end
    end

    // State after taking a bit, before the end-of-pass handling.
    always_comb begin
        pair_state                 = i_state;
        pair_state.path_bits[idx]  = take;
        pair_state.running_crc     = crc_shift(i_state.running_crc, take);
        if (fork_here && !take) begin
            pair_state.newest_zero_fork = pos;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.status = ST_NOT_IN_PASS;

        case (i_item.op)
            OP_RESTART: begin
                o_state         = StateReset;
                o_result.status = ST_RESTARTED;
            end
            OP_BEGIN: begin
                if (i_state.sweep_done) begin
                    o_result.status = ST_SWEEP_OVER;
                end else if (!i_item.presence) begin
                    o_state.sweep_done = 1'b1;
                    o_state.in_pass    = 1'b0;
                    o_result.status    = ST_NO_DEVICE;
                end else begin
                    o_state.in_pass          = 1'b1;
                    o_state.bit_position     = PosW'(1);
                    o_state.newest_zero_fork = '0;
                    o_state.running_crc      = 8'h00;
                    o_result.status          = ST_PASS_START;
                end
            end
            OP_PAIR: begin
                if (i_state.in_pass) begin
                    if (i_item.id_bit && i_item.cmp_bit) begin
                        o_state.sweep_done = 1'b1;
                        o_state.in_pass    = 1'b0;
                        o_result.status    = ST_NO_RESPONSE;
                    end else begin
                        o_state            = pair_state;
                        o_result.write_bit = take;
                        if (pos >= PosW'(RomBits)) begin
                            // Last bit: the newest 0-leg fork is where the next pass turns.
                            o_state.last_fork = pair_state.newest_zero_fork;
                            if (pair_state.newest_zero_fork == '0) begin
                                o_state.sweep_done = 1'b1;
                            end
                            o_state.in_pass     = 1'b0;
                            o_result.rom_code   = pair_state.path_bits;
                            o_result.rom_crc_ok = (pair_state.running_crc == 8'h00);
                            o_result.status     = ST_ROM_DONE;
                        end else begin
                            o_state.bit_position = pos + PosW'(1);
                            o_result.status      = ST_BIT_TAKEN;
                        end
                    end
                end
            end
            default: begin
                o_result.status = ST_NOT_IN_PASS;
            end
        endcase

        o_result.sweep_finished = o_state.sweep_done;
    end

endmodule

`default_nettype wire

FILE: rtl/core/onewire_rom_search_core.sv
// ROM search core: input register, step logic, search state and result register.
// Flow: an accepted item is held in the input register, then stepped into
// the result register while that register is free or being emptied.
// Throughput: one item per cycle while the output keeps accepting; owrs_step
// is combinational; a stalled full result register stops the step and then the input.
// Reset (synchronous, active low) empties both registers and restores the
// search state to the start of a fresh sweep.
`default_nettype none

module onewire_rom_search_core
    import owrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // op[1:0], presence, id_bit, cmp_bit, zero fill
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata   // status[2:0], write_bit, rom_code[63:0],
                                              // rom_crc_ok, sweep_finished, zero fill
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    out_free;
    logic    step_fire;

    owrs_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step_fire       = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= StateReset;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item <= t_item'(i_s_axis_tdata[4:0]);
        end
        if (step_fire) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_result};

endmodule

`default_nettype wire
